[design/slm_pkg.sv]
// Package for sorted_list_merge: sizes, command codes, controller/datapath structs.
// No dependencies.
package slm_pkg;
  localparam int unsigned TotalDef = 1024;
  localparam int unsigned ListsDef = 16;
  localparam int unsigned VAL_W = 32;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_POP  = 1'b1
  } cmd_e;

  // controller -> datapath
  typedef struct packed {
    logic load;       // store one element
    logic scan_start; // reset scan index and best
    logic scan_step;  // one phase (read or compare) of one list
    logic pop;        // commit best, advance head
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_done;
    logic empty;
  } dp_sts_t;
endpackage

[design/slm_if.sv]
// Valid/ready channel interface carrying one payload word.
// Depends on nothing; payload type is a parameter.
interface slm_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[design/slm_datapath.sv]
// Datapath: element memory, list head/end tables, sequential minimum scan.
// Depends on slm_pkg.
module slm_datapath #(
  parameter int unsigned TOTAL = slm_pkg::TotalDef,
  parameter int unsigned LISTS = slm_pkg::ListsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  slm_pkg::dp_cmd_t            cmd_i,
  input  logic signed [31:0]          value_i,
  input  logic                        eol_i,
  output slm_pkg::dp_sts_t            sts_o,
  output logic signed [31:0]          merged_value_o,
  output logic                        last_o,
  output logic                        overflow_o
);
  import slm_pkg::*;
  localparam int unsigned AW = $clog2(TOTAL);
  localparam int unsigned PW = $clog2(TOTAL + 1);
  localparam int unsigned LW = $clog2(LISTS);
  localparam int unsigned CW = $clog2(LISTS + 1);

  logic signed [31:0] mem_q [TOTAL];
  logic [PW-1:0] head_q [LISTS];
  logic [PW-1:0] end_q  [LISTS];
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] wp_q, rem_q, start_q;
  logic          ovf_q;

  logic [CW-1:0]      idx_q;
  logic [LW-1:0]      best_q;
  logic               found_q;
  logic signed [31:0] bestv_q;
  logic signed [31:0] rd_q;
  logic               rdok_q;
  logic               phase_q; // 0: read issued, 1: data ready

  logic room;
  assign room = (wp_q < PW'(TOTAL)) && (cnt_q < CW'(LISTS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load && room) mem_q[wp_q[AW-1:0]] <= value_i;
  end

  // registered memory read for the scanned list head
  logic [LW-1:0] ridx;
  assign ridx = idx_q[LW-1:0];
  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[head_q[ridx][AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0; wp_q <= '0; rem_q <= '0; ovf_q <= 1'b0; start_q <= '0;
      idx_q <= '0; found_q <= 1'b0; phase_q <= 1'b0; rdok_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        if (!room) ovf_q <= 1'b1;
        else begin
          wp_q <= wp_q + 1'b1;
          if (eol_i) begin
            head_q[cnt_q[LW-1:0]] <= start_q;
            end_q[cnt_q[LW-1:0]]  <= wp_q + 1'b1;
            start_q <= wp_q + 1'b1;
            rem_q   <= rem_q + (wp_q + 1'b1 - start_q);
            cnt_q   <= cnt_q + 1'b1;
          end
        end
      end
      if (cmd_i.scan_start) begin
        idx_q <= '0; found_q <= 1'b0; phase_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        if (!phase_q) begin
          rdok_q  <= head_q[ridx] < end_q[ridx];
          phase_q <= 1'b1;
        end else begin
          if (rdok_q && (!found_q || rd_q < bestv_q)) begin
            found_q <= 1'b1; best_q <= ridx; bestv_q <= rd_q;
          end
          idx_q <= idx_q + 1'b1;
          phase_q <= 1'b0;
        end
      end
      if (cmd_i.pop && found_q) begin
        head_q[best_q] <= head_q[best_q] + 1'b1;
        rem_q <= rem_q - 1'b1;
      end
    end
  end

  assign sts_o.scan_done = (idx_q >= cnt_q);
  assign sts_o.empty     = (rem_q == '0);
  assign merged_value_o  = bestv_q;
  assign last_o          = (rem_q == '0);
  assign overflow_o      = ovf_q;

  a_rem_le_wp: assert property (@(posedge clk_i) disable iff (!rst_ni) rem_q <= wp_q)
    else $error("remaining exceeds stored");
  a_cnt_max: assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CW'(LISTS))
    else $error("list count overflow");
  a_wp_max: assert property (@(posedge clk_i) disable iff (!rst_ni) wp_q <= PW'(TOTAL))
    else $error("write pointer overflow");
endmodule

[design/slm_ctrl.sv]
// Controller: accepts words, sequences the head scan, drives the result register.
// Depends on slm_pkg.
module slm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_cmd_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             res_valid_o,
  output slm_pkg::dp_cmd_t cmd_o,
  input  slm_pkg::dp_sts_t sts_i
);
  import slm_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SCAN = 4'b0010,
    S_POP  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;
  state_e state_q, state_d;
  logic   rv_q, rv_d;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_OUT);
  assign res_valid_o = rv_q;

  always_comb begin
    state_d = state_q;
    rv_d    = rv_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          if (in_cmd_i == CMD_LOAD) cmd_o.load = 1'b1;
          else if (sts_i.empty) begin
            rv_d = 1'b0; state_d = S_OUT;
          end else begin
            cmd_o.scan_start = 1'b1; state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (sts_i.scan_done) state_d = S_POP;
        else cmd_o.scan_step = 1'b1;
      end
      S_POP: begin
        cmd_o.pop = 1'b1; rv_d = 1'b1; state_d = S_OUT;
      end
      S_OUT: begin
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; rv_q <= 1'b0;
    end else begin
      state_q <= state_d; rv_q <= rv_d;
    end
  end

  a_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state not one-hot");
  a_pop_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_POP |=> state_q == S_OUT && rv_q)
    else $error("pop not followed by result");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped");
endmodule

[design/sorted_list_merge.sv]
// sorted_list_merge: k-way merge of sorted signed lists. Load words (cmd=0) append an
// element; end_of_list closes a list. A pop word (cmd=1) returns the smallest head,
// lowest list index on ties. A pop scans the closed lists in turn through the element
// memory read port, a read phase then a compare phase per list; no new word is accepted
// until its result has been taken. Results without an element (valid_res=0) carry
// merged_value 0.
module sorted_list_merge #(
  parameter int unsigned TOTAL = slm_pkg::TotalDef,
  parameter int unsigned LISTS = slm_pkg::ListsDef
) (
  input logic clk_i,
  input logic rst_ni,
  slm_if.sink   in_i,
  slm_if.source out_o
);
  import slm_pkg::*;
  dp_cmd_t cmd;
  dp_sts_t sts;
  logic signed [31:0] mv;
  logic last, ovf, rv;

  slm_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_i.valid), .in_cmd_i(in_i.data.cmd), .in_ready_o(in_i.ready),
    .out_valid_o(out_o.valid), .out_ready_i(out_o.ready), .res_valid_o(rv),
    .cmd_o(cmd), .sts_i(sts)
  );

  slm_datapath #(.TOTAL(TOTAL), .LISTS(LISTS)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .value_i(in_i.data.value),
    .eol_i(in_i.data.end_of_list), .sts_o(sts), .merged_value_o(mv),
    .last_o(last), .overflow_o(ovf)
  );

  assign out_o.data.merged_value = rv ? mv : '0;
  assign out_o.data.valid_res    = rv;
  assign out_o.data.last         = rv && last;
  assign out_o.data.overflow     = ovf;
endmodule

[test/slm_tb_pkg.sv]
`timescale 1ns / 100ps
// Word types for the sorted_list_merge channels, shared by the bench and its checker.
// Depends on slm_pkg.
package slm_tb_pkg;
  import slm_pkg::*;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [31:0] value;
    logic               end_of_list;
  } slm_in_word_t;

  typedef struct packed {
    logic signed [31:0] merged_value;
    logic               valid_res;
    logic               last;
    logic               overflow;
  } slm_out_word_t;
endpackage

[test/slm_merge_checker.sv]
`timescale 1ns / 100ps
// Checker for sorted_list_merge: mirrors the list store, predicts each pop result
// and compares it with the output words. Depends on slm_pkg, slm_tb_pkg and slm_if.
module slm_merge_checker
  import slm_pkg::*;
  import slm_tb_pkg::*;
(
  input  logic clk_i,
  slm_if       in_mon_i,
  slm_if       out_mon_i,
  output int   fails_o,
  output int   pending_o
);
  localparam int unsigned TOTAL = TotalDef;
  localparam int unsigned LISTS = ListsDef;

  logic signed [31:0] store_mem [TOTAL];
  int unsigned        head_pos [LISTS];
  int unsigned        end_pos [LISTS];
  int unsigned        closed_lists = 0;
  int unsigned        wr_ptr = 0;
  int unsigned        unpopped = 0;
  logic               dropped_seen = 1'b0;
  slm_out_word_t      pop_q [$];
  int                 fails = 0;

  assign fails_o   = fails;
  assign pending_o = pop_q.size();

  function automatic slm_out_word_t next_smallest();
    slm_out_word_t r;
    int            pick;
    r = '0;
    r.overflow = dropped_seen;
    if (unpopped == 0) return r;
    pick = -1;
    for (int k = 0; k < closed_lists; k++) begin
      if (head_pos[k] < end_pos[k]) begin
        if (pick < 0 || store_mem[head_pos[k]] < store_mem[head_pos[pick]]) pick = k;
      end
    end
    if (pick < 0) return r;
    r.merged_value = store_mem[head_pos[pick]];
    r.valid_res = 1'b1;
    head_pos[pick]++;
    unpopped--;
    r.last = (unpopped == 0);
    return r;
  endfunction

  always @(posedge clk_i) begin
    slm_in_word_t  w;
    slm_out_word_t got;
    slm_out_word_t exp;
    int unsigned   start;
    if (in_mon_i.valid && in_mon_i.ready) begin
      w = in_mon_i.data;
      if (w.cmd == CMD_POP) begin
        pop_q.push_back(next_smallest());
      end else if (wr_ptr >= TOTAL || closed_lists >= LISTS) begin
        dropped_seen = 1'b1;
      end else begin
        store_mem[wr_ptr] = w.value;
        wr_ptr++;
        if (w.end_of_list) begin
          start = (closed_lists == 0) ? 0 : end_pos[closed_lists - 1];
          head_pos[closed_lists] = start;
          end_pos[closed_lists] = wr_ptr;
          unpopped += wr_ptr - start;
          closed_lists++;
        end
      end
    end
    if (out_mon_i.valid && out_mon_i.ready) begin
      got = out_mon_i.data;
      if (pop_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected word val=%0d v=%b l=%b o=%b", $time,
                 got.merged_value, got.valid_res, got.last, got.overflow);
      end else begin
        exp = pop_q.pop_front();
        if (got.valid_res !== exp.valid_res || got.last !== exp.last ||
            got.overflow !== exp.overflow ||
            got.merged_value !== exp.merged_value) begin
          fails++;
          $display("%0t: mismatch exp val=%0d v=%b l=%b o=%b, got val=%0d v=%b l=%b o=%b",
                   $time, exp.merged_value, exp.valid_res, exp.last, exp.overflow,
                   got.merged_value, got.valid_res, got.last, got.overflow);
        end
      end
    end
  end
endmodule

[test/tb_sorted_list_merge.sv]
`timescale 1ns / 100ps
// Testbench top for sorted_list_merge: directed and random list loads and pops
// with idling on both channels. Depends on slm_pkg, slm_tb_pkg, slm_if, the checker.
module tb_sorted_list_merge;
  import slm_pkg::*;
  import slm_tb_pkg::*;

  localparam int STALL_LIMIT = 3000;

  logic clk_i;
  logic rst_ni;
  int   fails;
  int   pending;
  logic calm = 1'b0;
  int   stall = 0;
  int   idle_cycles = 0;

  int held = 0;
  int lists_closed = 0;
  int open_len = 0;
  int rem = 0;

  slm_if #(.T(slm_in_word_t))  in_if ();
  slm_if #(.T(slm_out_word_t)) out_if ();

  sorted_list_merge u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  slm_merge_checker u_chk (
    .clk_i     (clk_i),
    .in_mon_i  (in_if),
    .out_mon_i (out_if),
    .fails_o   (fails),
    .pending_o (pending)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(negedge clk_i) begin
    if (stall > 0) begin
      stall <= stall - 1;
      out_if.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall <= $urandom_range(1, 16) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_sorted_list_merge: done, errors");
      $finish;
    end
  end

  task automatic send(input cmd_e cmd, input logic [31:0] v, input logic eol);
    slm_in_word_t w;
    w.cmd = cmd;
    w.value = v;
    w.end_of_list = eol;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= w;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
  endtask

  task automatic load(input logic [31:0] v, input logic eol);
    if (held < TotalDef && lists_closed < ListsDef) begin
      held++;
      open_len++;
      if (eol) begin
        rem += open_len;
        open_len = 0;
        lists_closed++;
      end
    end
    send(CMD_LOAD, v, eol);
  endtask

  task automatic pop();
    if (rem > 0) rem--;
    send(CMD_POP, $urandom, $urandom_range(0, 1));
  endtask

  task automatic load_list(input int len, input bit ordered, input bit mix_pops);
    int vals [$];
    for (int i = 0; i < len; i++) vals.push_back(int'($urandom));
    if (ordered) vals.sort();
    for (int i = 0; i < len; i++) begin
      if (mix_pops && rem > 0 && $urandom_range(0, 7) == 0) pop();
      load(vals[i], i == len - 1);
    end
  endtask

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: empty pop, extremes, tie across lists, open list
    pop();
    load(32'h8000_0000, 1'b0);
    load(32'd5, 1'b0);
    load(32'h7fff_ffff, 1'b1);
    load(32'd5, 1'b1);
    pop();
    load(32'd3, 1'b0);
    repeat (4) pop();
    pop();
    load(32'hffff_ffff, 1'b1);
    pop();
    pop();
    pop();

    // random lists, pops mixed in
    for (int li = 0; li < 11; li++) begin
      load_list($urandom_range(1, 80), $urandom_range(0, 9) != 0, 1'b1);
      repeat ($urandom_range(0, rem / 4)) pop();
    end

    // fill the store to the last entry with the last list slots
    calm = 1'b1;
    load_list(TotalDef - 1 - held, 1'b1, 1'b0);
    load(32'd0, 1'b1);
    repeat (4) load($urandom, $urandom_range(0, 1));
    repeat (24) pop();

    in_if.valid <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (fails == 0) begin
      $display("tb_sorted_list_merge: done, clean");
    end else begin
      $display("tb_sorted_list_merge: done, errors");
    end
    $finish;
  end
endmodule

[files.f]
design/slm_pkg.sv
design/slm_if.sv
design/slm_datapath.sv
design/slm_ctrl.sv
design/sorted_list_merge.sv
test/slm_tb_pkg.sv
test/slm_merge_checker.sv
test/tb_sorted_list_merge.sv
